### hw/rtl/gdtm_pkg.sv
// shared types, codes and helpers of the grid orientation matcher
package gdtm_pkg;

  localparam int MaxSideDefault = 16;
  localparam int CmdW           = 2;
  localparam int RowW           = 4;
  localparam int ColW           = 4;
  localparam int CellW          = 8;
  localparam int GridSizeW      = 5;
  localparam int CodeW          = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_SRC = 2'd0,
    CMD_LOAD_TGT = 2'd1,
    CMD_CLASSIFY = 2'd2
  } cmd_e;

  // transforms in the order they are tried
  typedef enum logic [2:0] {
    XF_ROT90      = 3'd0,
    XF_ROT180     = 3'd1,
    XF_ROT270     = 3'd2,
    XF_MIRROR     = 3'd3,
    XF_MIR_ROT90  = 3'd4,
    XF_MIR_ROT180 = 3'd5,
    XF_MIR_ROT270 = 3'd6,
    XF_IDENT      = 3'd7
  } xform_e;

  localparam logic [CodeW-1:0] TC_ROT90      = 3'd0;
  localparam logic [CodeW-1:0] TC_ROT180     = 3'd1;
  localparam logic [CodeW-1:0] TC_ROT270     = 3'd2;
  localparam logic [CodeW-1:0] TC_MIRROR     = 3'd3;
  localparam logic [CodeW-1:0] TC_MIRROR_ROT = 3'd4;
  localparam logic [CodeW-1:0] TC_SAME       = 3'd5;
  localparam logic [CodeW-1:0] TC_NONE       = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_CHECK
  } state_e;

  typedef struct packed {
    logic load_src;
    logic load_tgt;
    logic walk_init;
    logic walk_step;
    logic next_xform;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic size_zero;
    logic last_cell;
    logic matched;
    logic last_xform;
  } ctl_sts_t;

  function automatic logic [CodeW-1:0] xform_code(xform_e xf);
    logic [CodeW-1:0] code;
    unique case (xf)
      XF_ROT90:  code = TC_ROT90;
      XF_ROT180: code = TC_ROT180;
      XF_ROT270: code = TC_ROT270;
      XF_MIRROR: code = TC_MIRROR;
      XF_MIR_ROT90, XF_MIR_ROT180, XF_MIR_ROT270: code = TC_MIRROR_ROT;
      default:   code = TC_SAME;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/gdtm_ctrl.sv
// controller state machine of the grid orientation matcher
module gdtm_ctrl
  import gdtm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CmdW-1:0]  cmd_i,
  input  ctl_sts_t         sts_i,
  output ctl_cmd_t         cmd_o,
  output logic             busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            CMD_LOAD_SRC: cmd_o.load_src = 1'b1;
            CMD_LOAD_TGT: cmd_o.load_tgt = 1'b1;
            CMD_CLASSIFY: begin
              // empty window matches vacuously
              if (sts_i.size_zero) begin
                cmd_o.emit = 1'b1;
              end else begin
                cmd_o.walk_init = 1'b1;
                state_d         = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.last_cell) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.matched || sts_i.last_xform) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.next_xform = 1'b1;
          state_d          = S_WALK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  a_check_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> $past(state_q) == S_DRAIN)
    else $error("check state not preceded by drain");

  a_emit_not_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == S_IDLE)
    else $error("result emitted while a walk continues");

endmodule

### hw/rtl/gdtm_dp.sv
// datapath: grid memories, cell walk counters, compare stage and result register
module gdtm_dp
  import gdtm_pkg::*;
#(
  parameter int MAX_SIDE = MaxSideDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctl_cmd_t              cmd_i,
  output ctl_sts_t              sts_o,
  input  logic [RowW-1:0]       row_i,
  input  logic [ColW-1:0]       col_i,
  input  logic [CellW-1:0]      cell_value_i,
  input  logic                  grid_size_we_i,
  input  logic [GridSizeW-1:0]  grid_size_i,
  output logic                  result_valid_o,
  output logic [CodeW-1:0]      transform_code_o
);

  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int EXT_W  = (CNT_W > GridSizeW) ? CNT_W : GridSizeW;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [GridSizeW-1:0] grid_size_q;
  logic [EXT_W-1:0]     gs_ext;
  logic [CNT_W-1:0]     side;
  logic [CNT_W-1:0]     side_m1;
  logic [IDX_W-1:0]     last_idx;

  logic [CellW-1:0]     src_mem [DEPTH];
  logic [CellW-1:0]     tgt_mem [DEPTH];
  logic [CellW-1:0]     src_rd_q, tgt_rd_q;
  logic                 cmp_vld_q;
  logic                 mismatch_q;

  logic [IDX_W-1:0]     r_q, c_q;
  xform_e               xform_q;
  logic [IDX_W-1:0]     rr, cc, sr, sc;

  logic [EXT_W-1:0]     row_ext, col_ext;
  logic                 load_ok;
  logic [ADDR_W-1:0]    load_addr;
  logic [ADDR_W-1:0]    src_addr, tgt_addr;

  logic                 result_valid_q;
  logic [CodeW-1:0]     transform_code_q;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GridSizeW'(1);
    end else if (grid_size_we_i) begin
      grid_size_q <= grid_size_i;
    end
  end

  // window side saturates at the storage side
  assign gs_ext   = EXT_W'(grid_size_q);
  assign side     = (gs_ext > EXT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(gs_ext);
  assign side_m1  = side - CNT_W'(1);
  assign last_idx = IDX_W'(side_m1);

  // load addressing, out of range loads are dropped
  assign row_ext   = EXT_W'(row_i);
  assign col_ext   = EXT_W'(col_i);
  assign load_ok   = (row_ext < EXT_W'(MAX_SIDE)) && (col_ext < EXT_W'(MAX_SIDE));
  assign load_addr = {IDX_W'(row_ext), IDX_W'(col_ext)};

  // source cell that lands on (r, c) under the current transform
  assign rr = last_idx - r_q;
  assign cc = last_idx - c_q;

  always_comb begin
    unique case (xform_q)
      XF_ROT90:      begin sr = cc;  sc = r_q; end
      XF_ROT180:     begin sr = rr;  sc = cc;  end
      XF_ROT270:     begin sr = c_q; sc = rr;  end
      XF_MIRROR:     begin sr = r_q; sc = cc;  end
      XF_MIR_ROT90:  begin sr = cc;  sc = rr;  end
      XF_MIR_ROT180: begin sr = rr;  sc = c_q; end
      XF_MIR_ROT270: begin sr = c_q; sc = r_q; end
      default:       begin sr = r_q; sc = c_q; end
    endcase
  end

  assign src_addr = {sr, sc};
  assign tgt_addr = {r_q, c_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_src && load_ok) begin
      src_mem[load_addr] <= cell_value_i;
    end
    src_rd_q <= src_mem[src_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tgt && load_ok) begin
      tgt_mem[load_addr] <= cell_value_i;
    end
    tgt_rd_q <= tgt_mem[tgt_addr];
  end

  // walk counters, column fastest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q     <= '0;
      c_q     <= '0;
      xform_q <= XF_ROT90;
    end else if (cmd_i.walk_init) begin
      r_q     <= '0;
      c_q     <= '0;
      xform_q <= XF_ROT90;
    end else if (cmd_i.next_xform) begin
      r_q     <= '0;
      c_q     <= '0;
      xform_q <= xform_e'(xform_q + 3'd1);
    end else if (cmd_i.walk_step) begin
      if (c_q == last_idx) begin
        c_q <= '0;
        r_q <= r_q + IDX_W'(1);
      end else begin
        c_q <= c_q + IDX_W'(1);
      end
    end
  end

  // compare stage behind the registered memory reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q  <= 1'b0;
      mismatch_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.walk_step;
      if (cmd_i.walk_init || cmd_i.next_xform) begin
        mismatch_q <= 1'b0;
      end else if (cmp_vld_q && (src_rd_q != tgt_rd_q)) begin
        mismatch_q <= 1'b1;
      end
    end
  end

  assign sts_o.size_zero  = (grid_size_q == '0);
  assign sts_o.last_cell  = (r_q == last_idx) && (c_q == last_idx);
  assign sts_o.matched    = !mismatch_q;
  assign sts_o.last_xform = (xform_q == XF_IDENT);

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (sts_o.size_zero) begin
        transform_code_q <= TC_ROT90;
      end else if (!mismatch_q) begin
        transform_code_q <= xform_code(xform_q);
      end else begin
        transform_code_q <= TC_NONE;
      end
    end
  end

  assign result_valid_o   = result_valid_q;
  assign transform_code_o = transform_code_q;

  a_no_step_past_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.next_xform |-> xform_q != XF_IDENT)
    else $error("transform counter stepped past identity");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> transform_code_q <= TC_NONE)
    else $error("transform code out of range");

endmodule

### hw/rtl/grid_dihedral_transform_match_top.sv
// top level of the square grid orientation matcher
//
// Commands enter on start/busy: a command beat is taken at a clock edge with
// start high and busy low. Load source and load target write one byte cell
// at (row_i, col_i) and give no result, so loads stream one per cycle
// while busy is low. Classify compares the target grid with the symmetry
// transforms of the source over the top-left n x n window, n = grid_size
// saturated at MAX_SIDE. Transforms are tried in priority order, each by a
// walk over all n*n cells through one read port per grid memory, followed
// by a drain of the registered read and compare stage. A classify tries
// 1 to 8 transforms and busy stays high meanwhile. With n zero the
// result beat comes in the cycle after the command.
// The result beat is result_valid_o for one cycle with transform_code_o;
// the receiver cannot stall it. grid_size_we_i writes the size register;
// the user must use it only while the block is idle, and the block
// itself does not enforce this.
// Reset sets the size to 1 and returns to idle; grid memories are not
// cleared and a cell must be loaded before a classify reads it.
module grid_dihedral_transform_match_top
  import gdtm_pkg::*;
#(
  parameter int MAX_SIDE = MaxSideDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [CmdW-1:0]       cmd_i,
  input  logic [RowW-1:0]       row_i,
  input  logic [ColW-1:0]       col_i,
  input  logic [CellW-1:0]      cell_value_i,
  input  logic                  grid_size_we_i,
  input  logic [GridSizeW-1:0]  grid_size_i,
  output logic                  result_valid_o,
  output logic [CodeW-1:0]      transform_code_o
);

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  gdtm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .sts_i  (ctl_sts),
    .cmd_o  (ctl_cmd),
    .busy   (busy)
  );

  gdtm_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctl_cmd),
    .sts_o            (ctl_sts),
    .row_i            (row_i),
    .col_i            (col_i),
    .cell_value_i     (cell_value_i),
    .grid_size_we_i   (grid_size_we_i),
    .grid_size_i      (grid_size_i),
    .result_valid_o   (result_valid_o),
    .transform_code_o (transform_code_o)
  );

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while a classify is still running");

endmodule

### tb/grid_dihedral_transform_match_top_tb.sv
// testbench of the square grid orientation matcher: predicts and checks every classify
module grid_dihedral_transform_match_top_tb;
  import gdtm_pkg::*;

  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;
  localparam int ITEM_GOAL  = 1500;
  localparam int QUIET_FROM = 1300;
  localparam int LIMIT      = 1000000;

  // orientation predictor plus the queue of transform codes still owed by the block
  class orient_scoreboard;
    logic [CellW-1:0] src_grid [MaxSideDefault*MaxSideDefault];
    logic [CellW-1:0] tgt_grid [MaxSideDefault*MaxSideDefault];
    bit src_loaded [MaxSideDefault*MaxSideDefault];
    bit tgt_loaded [MaxSideDefault*MaxSideDefault];
    logic [GridSizeW-1:0] side;
    logic [CodeW-1:0] pending_codes [$];
    int errors;

    function new();
      side = 1;
      errors = 0;
    endfunction

    // side in use, saturated to the storage size
    function int window();
      return (side > MaxSideDefault) ? MaxSideDefault : int'(side);
    endfunction

    // source cell that lands at (r, c) under xf
    function logic [CellW-1:0] source_at(xform_e xf, int n, int r, int c);
      int sr, sc, rr, cc;
      rr = n - 1 - r;
      cc = n - 1 - c;
      case (xf)
        XF_ROT90:      begin sr = cc; sc = r;  end
        XF_ROT180:     begin sr = rr; sc = cc; end
        XF_ROT270:     begin sr = c;  sc = rr; end
        XF_MIRROR:     begin sr = r;  sc = cc; end
        XF_MIR_ROT90:  begin sr = cc; sc = rr; end
        XF_MIR_ROT180: begin sr = rr; sc = c;  end
        XF_MIR_ROT270: begin sr = c;  sc = r;  end
        default:       begin sr = r;  sc = c;  end
      endcase
      return src_grid[sr*MaxSideDefault + sc];
    endfunction

    function bit fits(xform_e xf, int n);
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          if (tgt_grid[r*MaxSideDefault + c] !== source_at(xf, n, r, c)) return 1'b0;
      return 1'b1;
    endfunction

    function logic [CodeW-1:0] predict_code();
      int n;
      n = window();
      if (fits(XF_ROT90, n))  return TC_ROT90;
      if (fits(XF_ROT180, n)) return TC_ROT180;
      if (fits(XF_ROT270, n)) return TC_ROT270;
      if (fits(XF_MIRROR, n)) return TC_MIRROR;
      if (fits(XF_MIR_ROT90, n) || fits(XF_MIR_ROT180, n) || fits(XF_MIR_ROT270, n))
        return TC_MIRROR_ROT;
      if (fits(XF_IDENT, n))  return TC_SAME;
      return TC_NONE;
    endfunction

    function void note_beat(logic [CmdW-1:0] cmd, logic [RowW-1:0] row,
                            logic [ColW-1:0] col, logic [CellW-1:0] val);
      int idx;
      idx = int'(row) * MaxSideDefault + int'(col);
      case (cmd)
        CMD_LOAD_SRC: begin
          src_grid[idx] = val;
          src_loaded[idx] = 1'b1;
        end
        CMD_LOAD_TGT: begin
          tgt_grid[idx] = val;
          tgt_loaded[idx] = 1'b1;
        end
        CMD_CLASSIFY: pending_codes.push_back(predict_code());
        default: ;
      endcase
    endfunction

    function void check_code(logic [CodeW-1:0] actual);
      logic [CodeW-1:0] want;
      if (pending_codes.size() == 0) begin
        $display("%0t: transform_code expected none actual %0d", $time, actual);
        errors++;
      end else begin
        want = pending_codes.pop_front();
        if (actual !== want) begin
          $display("%0t: transform_code expected %0d actual %0d", $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [CmdW-1:0]      cmd_i;
  logic [RowW-1:0]      row_i;
  logic [ColW-1:0]      col_i;
  logic [CellW-1:0]     cell_value_i;
  logic                 grid_size_we_i;
  logic [GridSizeW-1:0] grid_size_i;
  logic                 result_valid_o;
  logic [CodeW-1:0]     transform_code_o;

  orient_scoreboard sb = new();
  int sent = 0;
  int cycles = 0;

  grid_dihedral_transform_match_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .row_i            (row_i),
    .col_i            (col_i),
    .cell_value_i     (cell_value_i),
    .grid_size_we_i   (grid_size_we_i),
    .grid_size_i      (grid_size_i),
    .result_valid_o   (result_valid_o),
    .transform_code_o (transform_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("grid_dihedral_transform_match_top verification failed");
      $finish;
    end
  end

  // result beats are sampled mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_code(transform_code_o);
  end

  function automatic logic [CellW-1:0] cell_pick(logic [CellW-1:0] base, int spread);
    logic [CellW-1:0] v;
    case (spread)
      0:       v = base ^ {7'd0, 1'($urandom_range(0, 1))};
      1:       v = base + {6'd0, 2'($urandom_range(0, 3))};
      default: v = CellW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send(logic [CmdW-1:0] cmd, logic [RowW-1:0] row,
                      logic [ColW-1:0] col, logic [CellW-1:0] val);
    int gap;
    if (sent < QUIET_FROM && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= cmd;
    row_i        <= row;
    col_i        <= col;
    cell_value_i <= val;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    sb.note_beat(cmd, row, col, val);
    if (cmd != CMD_SPARE) sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending_codes.size() != 0);
  endtask

  task automatic set_size(logic [GridSizeW-1:0] v);
    wait_drained();
    // a trailing load or unused command may still be in flight
    repeat (4) @(posedge clk_i);
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    grid_size_we_i <= 1'b1;
    grid_size_i    <= v;
    @(posedge clk_i);
    grid_size_we_i <= 1'b0;
    sb.side = v;
  endtask

  // never let a classify read a cell that was not loaded
  task automatic classify_now();
    int n;
    n = sb.window();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (!sb.src_loaded[r*MaxSideDefault + c])
          send(CMD_LOAD_SRC, RowW'(r), ColW'(c), CellW'($urandom));
        if (!sb.tgt_loaded[r*MaxSideDefault + c])
          send(CMD_LOAD_TGT, RowW'(r), ColW'(c), CellW'($urandom));
      end
    if (sent < QUIET_FROM && $urandom_range(0, 7) == 0) wait_drained();
    send(CMD_CLASSIFY, RowW'($urandom), ColW'($urandom), CellW'($urandom));
  endtask

  // fresh source, target built as a transform of it, sometimes spoiled
  task automatic shaped_scene();
    int n, spread;
    logic [CellW-1:0] base;
    xform_e xf;
    n = sb.window();
    spread = $urandom_range(0, 3);
    base = CellW'($urandom);
    xf = xform_e'($urandom_range(0, 7));
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        send(CMD_LOAD_SRC, RowW'(r), ColW'(c), cell_pick(base, spread));
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        send(CMD_LOAD_TGT, RowW'(r), ColW'(c), sb.source_at(xf, n, r, c));
    if (n > 0 && $urandom_range(0, 3) == 0)
      send(CMD_LOAD_TGT, RowW'($urandom_range(0, n - 1)), ColW'($urandom_range(0, n - 1)),
           cell_pick(base, spread));
    classify_now();
  endtask

  task automatic tweak_scene();
    int n, k;
    n = sb.window();
    k = $urandom_range(1, 3);
    if (n > 0)
      repeat (k)
        send($urandom_range(0, 1) ? CMD_LOAD_TGT : CMD_LOAD_SRC,
             RowW'($urandom_range(0, n - 1)), ColW'($urandom_range(0, n - 1)),
             CellW'($urandom));
    classify_now();
    if ($urandom_range(0, 2) == 0) classify_now();
  endtask

  task automatic noise_scene();
    int k;
    k = $urandom_range(4, 12);
    repeat (k) begin
      if ($urandom_range(0, 5) == 0)
        send(CMD_SPARE, RowW'($urandom), ColW'($urandom), CellW'($urandom));
      else
        send($urandom_range(0, 1) ? CMD_LOAD_TGT : CMD_LOAD_SRC,
             RowW'($urandom), ColW'($urandom), CellW'($urandom));
    end
    classify_now();
  endtask

  initial begin
    int first_sizes [9] = '{1, 3, 16, 17, 31, 0, 2, 4, 5};
    int ph, pick;
    logic [GridSizeW-1:0] v;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    cmd_i          <= CMD_LOAD_SRC;
    row_i          <= '0;
    col_i          <= '0;
    cell_value_i   <= '0;
    grid_size_we_i <= 1'b0;
    grid_size_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-cell grids, far corner cells, unused command, empty window, mirrored 2x2 grid
    send(CMD_LOAD_SRC, 0, 0, 8'h00);
    send(CMD_LOAD_TGT, 0, 0, 8'h00);
    send(CMD_CLASSIFY, 0, 0, 8'h00);
    send(CMD_LOAD_TGT, 0, 0, 8'hFF);
    send(CMD_CLASSIFY, 4'hF, 4'hF, 8'hFF);
    send(CMD_LOAD_SRC, 4'hF, 4'hF, 8'hFF);
    send(CMD_LOAD_TGT, 4'hF, 4'h0, 8'h80);
    send(CMD_SPARE, 4'hF, 4'hF, 8'hFF);
    send(CMD_CLASSIFY, 0, 0, 8'h00);
    set_size(0);
    send(CMD_CLASSIFY, 0, 0, 8'h00);
    set_size(2);
    send(CMD_LOAD_SRC, 0, 0, 8'd1);
    send(CMD_LOAD_SRC, 0, 1, 8'd2);
    send(CMD_LOAD_SRC, 1, 0, 8'd3);
    send(CMD_LOAD_SRC, 1, 1, 8'd4);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++)
        send(CMD_LOAD_TGT, RowW'(r), ColW'(c), sb.source_at(XF_MIRROR, 2, r, c));
    send(CMD_CLASSIFY, 0, 0, 8'h00);

    ph = 0;
    while (sent < ITEM_GOAL) begin
      if (ph < 9) v = GridSizeW'(first_sizes[ph]);
      else if ($urandom_range(0, 9) == 0) v = GridSizeW'($urandom_range(0, 8));
      else v = GridSizeW'($urandom_range(1, 6));
      ph++;
      set_size(v);
      if (sb.window() >= MaxSideDefault) begin
        if (v == MaxSideDefault) shaped_scene();
        repeat (2) tweak_scene();
      end else begin
        repeat ($urandom_range(2, 5)) begin
          pick = $urandom_range(0, 19);
          if (pick < 12) shaped_scene();
          else if (pick < 17) tweak_scene();
          else noise_scene();
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    do @(negedge clk_i); while (busy);
    if (sb.errors == 0 && sb.pending_codes.size() == 0) begin
      $display("grid_dihedral_transform_match_top verification clean");
    end else begin
      $display("grid_dihedral_transform_match_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/gdtm_pkg.sv
hw/rtl/gdtm_ctrl.sv
hw/rtl/gdtm_dp.sv
hw/rtl/grid_dihedral_transform_match_top.sv
tb/grid_dihedral_transform_match_top_tb.sv
